### src/sct_pkg.sv
// Shared constants, widths and types for the Taylor series sine/cosine core.
// Used by sct_reduce, sct_term and sine_cosine_taylor_core; depends on nothing.
`default_nettype none

package sct_pkg;

  localparam int unsigned SERIES_TERMS_DEF = 6;

  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned FRAC_W  = 29;

  localparam int unsigned T_W    = 57;
  localparam int unsigned REM_W  = 52;
  localparam int unsigned RD_W   = 51;
  localparam int unsigned X_W    = 31;
  localparam int unsigned X2_W   = 33;
  localparam int unsigned M_W    = 32;
  localparam int unsigned ACC_W  = 35;
  localparam int unsigned DIV_W  = 9;
  localparam int unsigned PROD_W = 66;
  localparam int unsigned PQ_W   = 37;
  localparam int unsigned RC_W   = 37;
  localparam int unsigned RC_LO_W = 19;

  localparam logic [50:0] TWO_PI_Q48 = 51'h6487ED5110B46;
  localparam logic [49:0] PI_Q48     = 50'h3243F6A8885A3;

  localparam logic [M_W-1:0] ONE_Q29 = M_W'(1) << FRAC_W;

  localparam logic [X_W-1:0] X_MAX = X_W'((51'(PI_Q48) + 51'd262144) >> 19);

  typedef struct packed {
    logic                    neg;
    logic [X2_W-1:0]         x2;
    logic [M_W-1:0]          m_s;
    logic [M_W-1:0]          m_c;
    logic signed [ACC_W-1:0] acc_s;
    logic signed [ACC_W-1:0] acc_c;
  } lane_t;

  // Divisor k(k+1) of series term n: sine uses k = 2n, cosine k = 2n-1.
  function automatic logic [DIV_W-1:0] term_div(input int unsigned n, input logic is_cos);
    int unsigned k;
    k = is_cos ? (2 * n - 1) : (2 * n);
    return DIV_W'(k * (k + 1));
  endfunction

endpackage

`default_nettype wire

### src/sct_reduce.sv
// Six-stage range reduction of a Q8.24 angle to [-pi, pi] and the Q29 x and x^2.
// Depends on sct_pkg for constants and the lane_t word passed to the series stages.
`default_nettype none

module sct_reduce (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  logic signed [31:0]  angle_i,
  output logic                vld_o,
  output sct_pkg::lane_t      lane_o
);

  localparam int unsigned THI_W = sct_pkg::T_W - 40;
  localparam int unsigned RECIP_W = 22;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned K_W = 5;
  localparam int unsigned KP_W = THI_W + RECIP_W;
  localparam int unsigned SQ_W = 2 * sct_pkg::X_W + 1;
  localparam logic [72:0] RECIP_FULL = (73'd1 << 72) / 73'(sct_pkg::TWO_PI_Q48);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [5:0] vld_q;

  logic [31:0]               mag;
  logic [sct_pkg::T_W-1:0]   t_a_d, t_a_q, t_b_q;
  logic                      neg_a_q, neg_b_q, neg_c_q, neg_d_q, sgn_e_q, sgn_f_q;
  logic [KP_W-1:0]           k_prod;
  logic [K_W-1:0]            k_b_d, k_b_q;
  logic [sct_pkg::T_W-1:0]   k_mul, rem_full;
  logic [sct_pkg::REM_W-1:0] rem_c_d, rem_c_q;
  logic [sct_pkg::RD_W-1:0]  rem_d_d, rem_d_q;
  logic                      ge_pi;
  logic [sct_pkg::RD_W-1:0]  rmag, rsum;
  logic                      sgn_e_d;
  logic [sct_pkg::X_W-1:0]   x_e_d, x_e_q, x_f_q;
  logic [SQ_W-1:0]           sq;
  logic [sct_pkg::X2_W-1:0]  x2_f_d, x2_f_q;

  always_comb begin
    mag = angle_i[31] ? (~angle_i + 32'd1) : angle_i;
    t_a_d = sct_pkg::T_W'({mag, 24'd0}) + sct_pkg::T_W'(sct_pkg::PI_Q48);

    k_prod = KP_W'(t_a_q[sct_pkg::T_W-1 -: THI_W]) * KP_W'(RECIP);
    k_b_d = k_prod[RECIP_SHIFT +: K_W];

    k_mul = sct_pkg::T_W'(k_b_q) * sct_pkg::T_W'(sct_pkg::TWO_PI_Q48);
    rem_full = t_b_q - k_mul;
    rem_c_d = rem_full[sct_pkg::REM_W-1:0];

    if (rem_c_q >= sct_pkg::REM_W'(sct_pkg::TWO_PI_Q48)) begin
      rem_d_d = sct_pkg::RD_W'(rem_c_q - sct_pkg::REM_W'(sct_pkg::TWO_PI_Q48));
    end else begin
      rem_d_d = sct_pkg::RD_W'(rem_c_q);
    end

    ge_pi = rem_d_q >= sct_pkg::RD_W'(sct_pkg::PI_Q48);
    rmag = ge_pi ? (rem_d_q - sct_pkg::RD_W'(sct_pkg::PI_Q48))
                 : (sct_pkg::RD_W'(sct_pkg::PI_Q48) - rem_d_q);
    sgn_e_d = neg_d_q ? (rem_d_q > sct_pkg::RD_W'(sct_pkg::PI_Q48)) : !ge_pi;
    rsum = rmag + sct_pkg::RD_W'(262144);
    x_e_d = rsum[19 +: sct_pkg::X_W];

    sq = SQ_W'(x_e_q) * SQ_W'(x_e_q) + (SQ_W'(1) << (sct_pkg::FRAC_W - 1));
    x2_f_d = sq[sct_pkg::FRAC_W +: sct_pkg::X2_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_a_q   <= t_a_d;
      neg_a_q <= angle_i[31];
      t_b_q   <= t_a_q;
      k_b_q   <= k_b_d;
      neg_b_q <= neg_a_q;
      rem_c_q <= rem_c_d;
      neg_c_q <= neg_b_q;
      rem_d_q <= rem_d_d;
      neg_d_q <= neg_c_q;
      x_e_q   <= x_e_d;
      sgn_e_q <= sgn_e_d;
      x_f_q   <= x_e_q;
      x2_f_q  <= x2_f_d;
      sgn_f_q <= sgn_e_q;
    end
  end

  assign vld_o = vld_q[5];

  always_comb begin
    lane_o.neg   = sgn_f_q;
    lane_o.x2    = x2_f_q;
    lane_o.m_s   = sct_pkg::M_W'(x_f_q);
    lane_o.m_c   = sct_pkg::ONE_Q29;
    lane_o.acc_s = $signed(sct_pkg::ACC_W'(x_f_q));
    lane_o.acc_c = $signed(sct_pkg::ACC_W'(sct_pkg::ONE_Q29));
  end

endmodule

`default_nettype wire

### src/sct_term.sv
// One Taylor term for the sine and cosine lanes: multiply, divide by k(k+1), accumulate.
// Four register stages; depends on sct_pkg for widths, divisors and lane_t.
`default_nettype none

module sct_term #(
  parameter int unsigned TERM = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  sct_pkg::lane_t lane_i,
  output logic           vld_o,
  output sct_pkg::lane_t lane_o
);

  localparam int unsigned LO_W   = sct_pkg::PQ_W + sct_pkg::RC_LO_W;
  localparam int unsigned FULL_W = sct_pkg::PQ_W + sct_pkg::RC_W + 1;
  localparam int unsigned RCF_W  = sct_pkg::RC_W + 1;
  localparam int unsigned HI_W   = sct_pkg::RC_W - sct_pkg::RC_LO_W;
  localparam int unsigned EXT_W  = sct_pkg::ACC_W - sct_pkg::M_W;

  localparam logic [sct_pkg::DIV_W-1:0] D_SIN = sct_pkg::term_div(TERM, 1'b0);
  localparam logic [sct_pkg::DIV_W-1:0] D_COS = sct_pkg::term_div(TERM, 1'b1);
  localparam logic [RCF_W-1:0] RCF_SIN = (RCF_W'(1) << sct_pkg::PQ_W) / RCF_W'(D_SIN);
  localparam logic [RCF_W-1:0] RCF_COS = (RCF_W'(1) << sct_pkg::PQ_W) / RCF_W'(D_COS);
  localparam logic [1:0][sct_pkg::DIV_W-1:0] DV = {D_COS, D_SIN};
  localparam logic [1:0][sct_pkg::RC_W-1:0] RC =
    {RCF_COS[sct_pkg::RC_W-1:0], RCF_SIN[sct_pkg::RC_W-1:0]};
  localparam bit SUB = ((TERM % 2) == 1);

  logic [3:0] vld_q;

  sct_pkg::lane_t pl1_q, pl2_q, pl3_q, lane_d, lane_q;

  logic [1:0][sct_pkg::M_W-1:0]    m_in;
  logic [1:0][sct_pkg::PROD_W-1:0] p_d, p_q;
  logic [1:0][sct_pkg::PQ_W-1:0]   ph, ph2_q, ph3_q;
  logic [1:0][LO_W-1:0]            lo_d, lo_q;
  logic [1:0][FULL_W-1:0]          full;
  logic [1:0][sct_pkg::M_W-1:0]    qe_d, qe_q;
  logic [1:0][sct_pkg::PQ_W-1:0]   prd, rem;
  logic [1:0][sct_pkg::M_W-1:0]    qv;
  logic [1:0][sct_pkg::ACC_W-1:0]  qx;

  assign m_in = {lane_i.m_c, lane_i.m_s};

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p_d[l] = sct_pkg::PROD_W'(m_in[l]) * sct_pkg::PROD_W'(lane_i.x2)
             + (sct_pkg::PROD_W'(DV[l]) << (sct_pkg::FRAC_W - 1));
      ph[l] = p_q[l][sct_pkg::FRAC_W +: sct_pkg::PQ_W];
      lo_d[l] = LO_W'(ph[l]) * LO_W'(RC[l][sct_pkg::RC_LO_W-1:0]);
      full[l] = ((FULL_W'(ph2_q[l]) * FULL_W'(RC[l][sct_pkg::RC_W-1 -: HI_W]))
                 << sct_pkg::RC_LO_W) + FULL_W'(lo_q[l]);
      qe_d[l] = full[l][sct_pkg::PQ_W +: sct_pkg::M_W];
      prd[l] = sct_pkg::PQ_W'(qe_q[l]) * sct_pkg::PQ_W'(DV[l]);
      rem[l] = ph3_q[l] - prd[l];
      qv[l] = qe_q[l] + sct_pkg::M_W'(rem[l] >= sct_pkg::PQ_W'(DV[l]));
      qx[l] = {{EXT_W{1'b0}}, qv[l]};
    end
  end

  always_comb begin
    lane_d = pl3_q;
    lane_d.m_s = qv[0];
    lane_d.m_c = qv[1];
    if (SUB) begin
      lane_d.acc_s = pl3_q.acc_s - $signed(qx[0]);
      lane_d.acc_c = pl3_q.acc_c - $signed(qx[1]);
    end else begin
      lane_d.acc_s = pl3_q.acc_s + $signed(qx[0]);
      lane_d.acc_c = pl3_q.acc_c + $signed(qx[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl1_q  <= lane_i;
      p_q    <= p_d;
      pl2_q  <= pl1_q;
      ph2_q  <= ph;
      lo_q   <= lo_d;
      pl3_q  <= pl2_q;
      ph3_q  <= ph2_q;
      qe_q   <= qe_d;
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q[3];
  assign lane_o = lane_q;

endmodule

`default_nettype wire

### src/sine_cosine_taylor_core.sv
// Sine and cosine of a Q8.24 angle by Taylor series, results in saturated Q2.30.
// It accepts one angle per cycle except while the skid word is held.
// Six stages reduce the angle, each term takes four stages, and one output register follows.
// An output register with a skid word lets the pipeline run while a result waits.
// Reset clears all valid bits; data registers are not reset and there is no clearing pass.
// Depends on sct_pkg, sct_reduce and sct_term.
`default_nettype none

module sine_cosine_taylor_core #(
  parameter int unsigned SERIES_TERMS = sct_pkg::SERIES_TERMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] sine, [63:32] cosine
);

  localparam int unsigned SAT_W = sct_pkg::ACC_W + 1;

  function automatic logic [sct_pkg::OUT_W-1:0] sat_q30(
    input logic signed [sct_pkg::ACC_W-1:0] acc
  );
    logic [SAT_W-1:0] v;
    logic             fits;
    v = {acc, 1'b0};
    fits = (&v[SAT_W-1:sct_pkg::OUT_W-1]) | ~(|v[SAT_W-1:sct_pkg::OUT_W-1]);
    if (fits) begin
      return v[sct_pkg::OUT_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(sct_pkg::OUT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(sct_pkg::OUT_W-1){1'b1}}};
    end
  endfunction

  logic ce;
  logic in_vld;

  logic                 rd_vld;
  sct_pkg::lane_t       rd_lane;
  logic [SERIES_TERMS:0] vld_c;
  sct_pkg::lane_t       lane_c [SERIES_TERMS+1];

  logic signed [sct_pkg::ACC_W-1:0] sin_acc;
  logic [63:0] res_data;
  logic        arrive;

  logic        out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  logic [63:0] out_d, out_q, skid_d, skid_q;

  assign ce            = !skid_vld_q;
  assign s_axis_tready = ce;
  assign in_vld        = s_axis_tvalid && ce;

  sct_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ce),
    .vld_i   (in_vld),
    .angle_i (s_axis_tdata),
    .vld_o   (rd_vld),
    .lane_o  (rd_lane)
  );

  assign vld_c[0]  = rd_vld;
  assign lane_c[0] = rd_lane;

  for (genvar g = 0; g < SERIES_TERMS; g++) begin : g_term
    sct_term #(
      .TERM (g + 1)
    ) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (ce),
      .vld_i  (vld_c[g]),
      .lane_i (lane_c[g]),
      .vld_o  (vld_c[g+1]),
      .lane_o (lane_c[g+1])
    );
  end

  always_comb begin
    sin_acc = lane_c[SERIES_TERMS].neg ? -lane_c[SERIES_TERMS].acc_s
                                       : lane_c[SERIES_TERMS].acc_s;
    res_data = {sat_q30(lane_c[SERIES_TERMS].acc_c), sat_q30(sin_acc)};
    arrive = ce && vld_c[SERIES_TERMS];
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_d = arrive;
      out_d     = res_data;
    end else if (arrive) begin
      skid_vld_d = 1'b1;
      skid_d     = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("Skid word held while the output register is empty.");

  a_reduced_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld |-> (rd_lane.m_s <= sct_pkg::M_W'(sct_pkg::X_MAX)))
    else $error("Reduced angle magnitude exceeds pi.");

  a_no_neg_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[31:0] != 32'h8000_0000 &&
                       m_axis_tdata[63:32] != 32'h8000_0000))
    else $error("Sine or cosine reached negative full scale.");

endmodule

`default_nettype wire

### tb/sv/tb_sine_cosine_taylor_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for sine_cosine_taylor_core. It holds its own Taylor series model of
// the core and a scoreboard, and drives both stream ports with random gaps and stalls.
// Depends on sct_pkg and on the core's RTL only.

module tb_sine_cosine_taylor_core;

  localparam int unsigned SERIES_TERMS = sct_pkg::SERIES_TERMS_DEF;
  localparam longint TWO_PI_Q48 = longint'(sct_pkg::TWO_PI_Q48);
  localparam longint PI_Q48     = longint'(sct_pkg::PI_Q48);
  localparam longint Q30_MAX    = 64'sh7FFF_FFFF;
  localparam longint Q30_MIN    = -64'sh8000_0000;
  localparam bit [63:0] HALF_Q29 = 64'd1 << 28;
  localparam int RANDOM_ANGLES  = 800;
  localparam int IDLE_LIMIT     = 2000;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    logic [31:0] cosine;
    logic [31:0] sine;
  } trig_pair_t;

  class sincos_scoreboard;
    trig_pair_t pairs_due[$];
    int         mismatches = 0;

    function longint taylor_sum(bit [63:0] first, bit [63:0] x2, bit is_cos);
      bit [63:0]   m;
      bit [63:0]   d;
      longint      acc;
      int unsigned k;
      m   = first;
      acc = longint'(first);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
        k = is_cos ? (2 * n - 1) : (2 * n);
        d = 64'(k * (k + 1));
        m = ((m * x2) / d + HALF_Q29) >> 29;
        if (n % 2 == 1) begin
          acc -= longint'(m);
        end else begin
          acc += longint'(m);
        end
      end
      return acc;
    endfunction

    function logic [31:0] saturate_q30(longint acc_q29);
      longint v;
      v = acc_q29 * 2;
      if (v > Q30_MAX) v = Q30_MAX;
      if (v < Q30_MIN) v = Q30_MIN;
      return v[31:0];
    endfunction

    function trig_pair_t sincos_of(logic signed [31:0] angle);
      longint     big;
      longint     turns;
      longint     r;
      bit [63:0]  rmag;
      bit [63:0]  x;
      bit [63:0]  x2;
      longint     sum_s;
      trig_pair_t pair;
      big = longint'(angle) * 16777216;
      if (big >= 0) begin
        turns = (big + PI_Q48) / TWO_PI_Q48;
      end else begin
        turns = -((-big + PI_Q48) / TWO_PI_Q48);
      end
      r    = big - turns * TWO_PI_Q48;
      rmag = (r < 0) ? 64'(-r) : 64'(r);
      x    = (rmag + (64'd1 << 18)) >> 19;
      x2   = (x * x + HALF_Q29) >> 29;
      sum_s = taylor_sum(x, x2, 1'b0);
      if (r < 0) sum_s = -sum_s;
      pair.sine   = saturate_q30(sum_s);
      pair.cosine = saturate_q30(taylor_sum(64'd1 << 29, x2, 1'b1));
      return pair;
    endfunction

    function void note_angle(logic [31:0] angle);
      pairs_due.push_back(sincos_of(angle));
    endfunction

    function void check_word(logic [63:0] word);
      trig_pair_t got;
      trig_pair_t want;
      got = word;
      if (pairs_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, word);
        mismatches++;
        return;
      end
      want = pairs_due.pop_front();
      if (got.sine !== want.sine) begin
        $display("%0t: sine expected %h, got %h", $time, want.sine, got.sine);
        mismatches++;
      end
      if (got.cosine !== want.cosine) begin
        $display("%0t: cosine expected %h, got %h", $time, want.cosine, got.cosine);
        mismatches++;
      end
    endfunction

    function int pending();
      return pairs_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  sincos_scoreboard sb = new();
  bit               send_quiet = 1'b0;
  bit               recv_quiet = 1'b0;
  int               idle_cycles = 0;

  sine_cosine_taylor_core #(
    .SERIES_TERMS(SERIES_TERMS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Largest Q8.24 angle below an odd multiple j of pi, plus an offset.
  function automatic logic [31:0] near_odd_pi(int j, int offset);
    longint base;
    base = (longint'(j) * PI_Q48) >>> 24;
    return 32'(base + offset);
  endfunction

  task automatic send_angle(input logic [31:0] angle);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= angle;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_angle(angle);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int count;
    int stall;
    wait (rst_ni === 1'b1);
    count = 0;
    forever begin
      if (count % 48 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      stall = recv_quiet ? 0 : $urandom_range(0, 12);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata);
      count++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed[$];
    logic [31:0] angle;
    int          j;
    int          pick;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h0192_1FB5, 32'hFE6D_E04B, 32'h0648_7ED5,
                 32'h0400_0000, 32'hFC00_0000};
    foreach (directed[i]) send_angle(directed[i]);
    for (int s = 0; s < 6; s++) begin
      j = (s % 2 == 0) ? ((s == 4) ? 39 : 2 * s + 1) : -((s == 5) ? 39 : 2 * s - 1);
      send_angle(near_odd_pi(j, 0));
      send_angle(near_odd_pi(j, 1));
    end
    drain_results();

    for (int i = 0; i < RANDOM_ANGLES; i++) begin
      if (i % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ANGLES / 2) drain_results();
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        angle = $urandom();
      end else if (pick < 7) begin
        angle = 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      end else begin
        j     = 2 * $urandom_range(0, 39) - 39;
        angle = near_odd_pi(j, $urandom_range(0, 6) - 3);
      end
      send_angle(angle);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
